FILE: rtl/dep_pkg.sv
// Package for the delta escape pixel decoder.
// Holds the decode phase type, stream and register widths, and the escape helper.
// No dependencies.
package dep_pkg;

   localparam int WORD_W    = 16;
   localparam int WIDTH_W   = 13;
   localparam int HEIGHT_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd512;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd512;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_CODE   = 2'd1,
      PH_RAW    = 2'd2
   } phase_type;

   // Ones from the leading set bit downwards, so 2^d-1 for bit length d (at least 1).
   function automatic logic [WORD_W-1:0] escape_of(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] s;
      s = word;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      s = s | WORD_W'(1);
      return s;
   endfunction

endpackage

FILE: rtl/dep_if.sv
// Channel interfaces of the delta escape pixel decoder.
// Request, response and register write channels; depends on dep_pkg.
interface dep_req_if;
   import dep_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] code_word;
   modport source (output valid, output code_word, input ready);
   modport sink   (input valid, input code_word, output ready);
endinterface

interface dep_rsp_if;
   import dep_pkg::*;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] pixel_value;
   logic              image_done;
   modport source (output valid, output pixel_value, output image_done, input ready);
   modport sink   (input valid, input pixel_value, input image_done, output ready);
endinterface

interface dep_csr_if;
   import dep_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/delta_escape_pixel_decoder.sv
// Delta escape pixel decoder: rebuilds an image in raster order from delta words.
// A pixel appears on the response channel in the cycle after its final request.
// One request per cycle unless rsp stalls; row memory is read one column ahead.
// Header and escape requests give no response.
// Reset: synchronous; the block waits for a header, width and height return to 512.
// Depends on dep_pkg and the channel interfaces in dep_if.sv.
module delta_escape_pixel_decoder #(
   parameter int MAX_WIDTH = 4096
) (
   input logic    clock,
   input logic    reset,
   dep_req_if.sink   req_ch,
   dep_rsp_if.source rsp_ch,
   dep_csr_if.sink   csr_ch
);
   import dep_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   phase_type           phase_ff, phase_in;
   logic [WORD_W-1:0]   bias_ff, bias_in;
   logic [WORD_W-1:0]   escape_ff, escape_in;
   logic [COL_W-1:0]    column_ff, column_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [WORD_W-1:0]   left_ff, left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   pixel_ff, pixel_in;
   logic                done_ff, done_in;

   logic [WORD_W-1:0]   row_mem_ff [MAX_WIDTH];
   logic [WORD_W-1:0]   rd_data_ff;
   logic                fwd_ff;
   logic [WORD_W-1:0]   fwd_data_ff;

   logic                req_acc;
   logic                emit;
   logic                wr_en;
   logic [WORD_W-1:0]   top;
   logic [WORD_W-1:0]   pred;
   logic [WORD_W:0]     mean_sum;
   logic [WORD_W-1:0]   pixel;
   logic [CMP_W-1:0]    eff_width;
   logic [CMP_W-1:0]    col_next;
   logic [HEIGHT_W:0]   row_next;
   logic [HEIGHT_W:0]   eff_height;
   logic                row_end;
   logic                img_end;

   assign req_ch.ready = !reset && (rsp_ch.ready || !rsp_valid_ff);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = !reset;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pixel_value = pixel_ff;
   assign rsp_ch.image_done  = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_IMAGE_WIDTH) begin
            width_ff <= csr_ch.data[WIDTH_W-1:0];
         end else if (csr_ch.index == CSR_IMAGE_HEIGHT) begin
            height_ff <= csr_ch.data[HEIGHT_W-1:0];
         end
      end
   end

   always_comb begin
      eff_width = CMP_W'(width_ff);
      if (eff_width == '0) begin
         eff_width = CMP_W'(1);
      end else if (eff_width > CMP_W'(MAX_WIDTH)) begin
         eff_width = CMP_W'(MAX_WIDTH);
      end
      eff_height = (height_ff == '0) ? (HEIGHT_W+1)'(1) : {1'b0, height_ff};
      col_next   = CMP_W'(column_ff) + CMP_W'(1);
      row_next   = {1'b0, row_ff} + (HEIGHT_W+1)'(1);
      row_end    = col_next >= eff_width;
      img_end    = row_end && (row_next >= eff_height);
   end

   // Top neighbour: forwarded when the previous cycle wrote the entry now read.
   assign top      = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign mean_sum = {1'b0, left_ff} + {1'b0, top};

   always_comb begin
      if (row_ff == '0 && column_ff == '0) begin
         pred = '0;
      end else if (row_ff == '0) begin
         pred = left_ff;
      end else if (column_ff == '0) begin
         pred = top;
      end else begin
         pred = mean_sum[WORD_W:1];
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (req_acc) begin
         unique case (phase_ff)
            PH_CODE: begin
               if (req_ch.code_word == escape_ff) begin
                  phase_in = PH_RAW;
               end else if (img_end) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_RAW: begin
               phase_in = img_end ? PH_HEADER : PH_CODE;
            end
            default: begin
               phase_in = PH_CODE;
            end
         endcase
      end
   end

   // Datapath and outputs.
   always_comb begin
      emit      = 1'b0;
      pixel     = req_ch.code_word;
      bias_in   = bias_ff;
      escape_in = escape_ff;
      unique case (phase_ff)
         PH_CODE: begin
            emit  = req_ch.code_word != escape_ff;
            pixel = pred + req_ch.code_word - bias_ff;
         end
         PH_RAW: begin
            emit  = 1'b1;
            pixel = req_ch.code_word;
         end
         default: begin
            escape_in = escape_of(req_ch.code_word);
            bias_in   = escape_in >> 1;
         end
      endcase
      wr_en = req_acc && emit;

      column_in = column_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      if (wr_en) begin
         left_in = pixel;
         if (row_end) begin
            column_in = '0;
            if (img_end) begin
               row_in  = '0;
               left_in = '0;
            end else begin
               row_in = row_next[HEIGHT_W-1:0];
            end
         end else begin
            column_in = col_next[COL_W-1:0];
         end
      end
      if (!req_acc || phase_ff == PH_CODE || phase_ff == PH_RAW) begin
         bias_in   = bias_ff;
         escape_in = escape_ff;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      pixel_in     = pixel_ff;
      done_in      = done_ff;
      if (wr_en) begin
         rsp_valid_in = 1'b1;
         pixel_in     = pixel;
         done_in      = img_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         bias_ff      <= '0;
         escape_ff    <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bias_ff      <= bias_in;
         escape_ff    <= escape_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff    <= pixel_in;
      done_ff     <= done_in;
      fwd_ff      <= wr_en && (column_ff == column_in);
      fwd_data_ff <= pixel;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem_ff[column_ff] <= pixel;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= row_mem_ff[column_in];
   end

   a_bias_follows_escape: assert property (@(posedge clock) disable iff (reset)
      bias_ff == (escape_ff >> 1))
      else $error("bias does not match escape code");

   a_header_to_code: assert property (@(posedge clock) disable iff (reset)
      (req_acc && phase_ff == PH_HEADER) |=> (phase_ff == PH_CODE))
      else $error("header request did not start pixel decoding");

   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(wr_en))
      else $error("response raised without a pixel request");

   a_image_end_clears: assert property (@(posedge clock) disable iff (reset)
      (wr_en && img_end) |=> (phase_ff == PH_HEADER && column_ff == '0 && row_ff == '0
                              && left_ff == '0 && done_ff))
      else $error("image end did not return to header wait");

endmodule
